### rtl/core/mfpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfpt_pkg;

	localparam int unsigned PANEL_WIDTH_DEF  = 128;
	localparam int unsigned PANEL_HEIGHT_DEF = 64;
	localparam int unsigned ROWS_PER_PAGE    = 8;
	localparam int unsigned BYTE_W           = 8;

endpackage

`default_nettype wire

### rtl/core/mfpt_frame_store.sv
`timescale 1ns / 1ps
`default_nettype none

module mfpt_frame_store
	import mfpt_pkg::*;
#(
	parameter int unsigned DEPTH = PANEL_WIDTH_DEF * PANEL_HEIGHT_DEF / BYTE_W,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [BYTE_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output logic      [BYTE_W-1:0] rd_data,
	output logic                   clearing
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [AW-1:0]     clr_addr_q;
	logic              clearing_q;
	logic [BYTE_W-1:0] rd_data_q;

	// zero sweep over every entry after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

`default_nettype wire

### rtl/core/mono_fb_page_transpose.sv
`timescale 1ns / 1ps
`default_nettype none
// write transfer: stored in the cycle it is taken, next item may follow at once
// read transfer: page rows gathered into a registered result; in_stall high until then;
//   the frame memory has one read port and gives one row byte per cycle
// a finished result waits in the output register while the next item is taken
// reset: the frame memory is zeroed by a sweep of one byte per cycle over all 1024 bytes
//   at the default panel size ((PANEL_WIDTH+7)/8 * PANEL_HEIGHT), with in_stall held high

module mono_fb_page_transpose
	import mfpt_pkg::*;
#(
	parameter int unsigned PANEL_WIDTH  = PANEL_WIDTH_DEF,
	parameter int unsigned PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              req_type,
	input  wire logic [9:0]        frame_addr,
	input  wire logic [BYTE_W-1:0] frame_byte,
	input  wire logic [2:0]        page_index,
	input  wire logic [6:0]        column_index,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [BYTE_W-1:0] display_byte
);

	localparam int unsigned ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
	localparam int unsigned STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
	localparam int unsigned AW          = $clog2(STORE_BYTES);
	localparam int unsigned PAGE_SHIFT  = $clog2(ROWS_PER_PAGE);
	localparam int unsigned STEP_W      = PAGE_SHIFT + 1;
	localparam int unsigned ROW_W       = 8;
	localparam int unsigned COL_CMP_W   = 9;
	localparam int unsigned BIT_W       = $clog2(BYTE_W);

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_GATHER = 3'b010,
		ST_HOLD   = 3'b100
	} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;
	logic [AW-1:0]      ra_q;
	logic [ROW_W-1:0]   row_q;
	logic               col_ok_q;
	logic [BIT_W-1:0]   col_bit_q;
	logic [BYTE_W-1:0]  acc_q;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  display_byte_q;

	logic               issue_v_s1;
	logic               take_s1;
	logic [PAGE_SHIFT-1:0] k_s1;

	logic               accept;
	logic               rd_accept;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ROW_W-1:0]   row0;
	logic               row0_ok;
	logic               col_ok;
	logic [AW-1:0]      addr0;
	logic               gather_issue;
	logic               issue_v;
	logic               issue_take;
	logic [PAGE_SHIFT-1:0] issue_k;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [BYTE_W-1:0]  rd_data;
	logic               clearing;
	logic               pix;
	logic [BYTE_W-1:0]  acc_next;
	logic               last_s1;
	logic               out_free;
	logic               out_load;
	logic [BYTE_W-1:0]  out_data;

	mfpt_frame_store #(
		.DEPTH (STORE_BYTES),
		.AW    (AW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (frame_byte),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.clearing (clearing)
	);

	assign in_stall  = (state_q != ST_IDLE) || clearing;
	assign accept    = in_valid && !in_stall;
	assign rd_accept = accept && (req_type == REQ_READ);

	// writes beyond the store are dropped
	assign wr_en   = accept && (req_type == REQ_WRITE)
		&& (32'(frame_addr) < 32'(STORE_BYTES));
	assign wr_addr = AW'(frame_addr);

	// first row of the page; address arithmetic wraps harmlessly, only in-range rows read
	assign row0    = ROW_W'(page_index) << PAGE_SHIFT;
	assign row0_ok = row0 < ROW_W'(PANEL_HEIGHT);
	assign col_ok  = COL_CMP_W'(column_index) < COL_CMP_W'(PANEL_WIDTH);
	assign addr0   = AW'(AW'(row0) * AW'(ROW_BYTES)) + AW'(column_index >> 3);

	assign gather_issue = (state_q == ST_GATHER) && !step_q[PAGE_SHIFT];
	assign issue_v      = rd_accept || gather_issue;

	always_comb begin
		if (rd_accept) begin
			issue_take = row0_ok && col_ok;
			issue_k    = '0;
			rd_addr    = addr0;
		end else begin
			issue_take = (row_q < ROW_W'(PANEL_HEIGHT)) && col_ok_q;
			issue_k    = step_q[PAGE_SHIFT-1:0];
			rd_addr    = ra_q;
		end
	end

	assign rd_en = issue_v && issue_take;

	assign pix      = take_s1 && rd_data[col_bit_q];
	assign acc_next = acc_q | (pix ? (BYTE_W'(1) << k_s1) : '0);
	assign last_s1  = issue_v_s1 && (k_s1 == PAGE_SHIFT'(ROWS_PER_PAGE - 1));

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		out_load = 1'b0;
		out_data = acc_q;
		if ((state_q == ST_GATHER) && last_s1 && out_free) begin
			out_load = 1'b1;
			out_data = acc_next;
		end else if ((state_q == ST_HOLD) && out_free) begin
			out_load = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_v_s1 <= 1'b0;
			take_s1    <= 1'b0;
			k_s1       <= '0;
		end else begin
			issue_v_s1 <= issue_v;
			take_s1    <= issue_take;
			k_s1       <= issue_k;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (rd_accept) begin
						state_q <= ST_GATHER;
						step_q  <= STEP_W'(1);
					end
				end
				ST_GATHER: begin
					if (gather_issue) begin
						step_q <= step_q + STEP_W'(1);
					end
					if (last_s1) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_accept) begin
			ra_q      <= addr0 + AW'(ROW_BYTES);
			row_q     <= row0 + ROW_W'(1);
			col_ok_q  <= col_ok;
			col_bit_q <= column_index[BIT_W-1:0];
			acc_q     <= '0;
		end else begin
			if (gather_issue) begin
				ra_q  <= ra_q + AW'(ROW_BYTES);
				row_q <= row_q + ROW_W'(1);
			end
			if (issue_v_s1) begin
				acc_q <= acc_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			display_byte_q <= out_data;
		end
	end

	assign out_valid    = out_valid_q;
	assign display_byte = display_byte_q;

endmodule

`default_nettype wire
